>>> rtl/rvse_pkg.sv
// Shared opcodes, function codes, memory sizing and stage structs for the execute block.
package rvse_pkg;

  // Data memory sizing: byte count, 32-bit word count, word index width
  localparam int MEM_BYTES  = 16384;
  localparam int DMEM_WORDS = MEM_BYTES / 4;
  localparam int DMEM_AW    = $clog2(DMEM_WORDS);

  // Major opcodes
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;

  // Load widths
  localparam logic [2:0] F3_LB  = 3'b000;
  localparam logic [2:0] F3_LH  = 3'b001;
  localparam logic [2:0] F3_LW  = 3'b010;
  localparam logic [2:0] F3_LBU = 3'b100;
  localparam logic [2:0] F3_LHU = 3'b101;

  // Store widths
  localparam logic [2:0] F3_SB = 3'b000;
  localparam logic [2:0] F3_SH = 3'b001;
  localparam logic [2:0] F3_SW = 3'b010;

  // Register-immediate and register-register operations
  localparam logic [2:0] F3_ADDI = 3'b000;
  localparam logic [2:0] F3_SLLI = 3'b001;
  localparam logic [2:0] F3_SRI  = 3'b101;
  localparam logic [2:0] F3_ANDI = 3'b111;
  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_JALR = 3'b000;

  // Branch conditions
  localparam logic [2:0] F3_BEQ  = 3'b000;
  localparam logic [2:0] F3_BNE  = 3'b001;
  localparam logic [2:0] F3_BLT  = 3'b100;
  localparam logic [2:0] F3_BGE  = 3'b101;
  localparam logic [2:0] F3_BLTU = 3'b110;
  localparam logic [2:0] F3_BGEU = 3'b111;

  // funct7 selectors
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [6:0] F7_MUL  = 7'b0000001;

  // Result of the execute stage, carried into writeback
  typedef struct packed {
    logic [31:0] npc;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic        is_load;
    logic [2:0]  ld_f3;
    logic        mem_write;
    logic [31:0] maddr;
    logic        mis;
    logic        uns;
  } exec_res_t;

  // Data memory access request
  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic [3:0]  be;
    logic [31:0] wdata;
  } mem_req_t;

endpackage

>>> rtl/rvse_exec.sv
// Execute-stage decode, address generation, ALU, branch and store-lane logic.
module rvse_exec (
  input  logic [31:0]        ins,
  input  logic [31:0]        pc,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  output rvse_pkg::exec_res_t res,
  output rvse_pkg::mem_req_t  req
);
  import rvse_pkg::*;

  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  shamt;
  logic [31:0] immi;
  logic [31:0] imms;
  logic [31:0] immb;
  logic [31:0] immj;
  logic [31:0] pc4;
  logic [31:0] agen;
  logic [31:0] btgt;
  logic [31:0] prod;
  logic        take;

  // Split fields and build immediates
  assign op    = ins[6:0];
  assign rd    = ins[11:7];
  assign f3    = ins[14:12];
  assign f7    = ins[31:25];
  assign shamt = ins[24:20];
  assign immi  = {{20{ins[31]}}, ins[31:20]};
  assign imms  = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign immb  = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign immj  = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

  // Shared adders: rs1 + immediate, and PC-relative target
  assign pc4  = pc + 32'd4;
  assign agen = a + ((op == OP_STORE) ? imms : immi);
  assign btgt = pc + ((op == OP_JAL) ? immj : immb);
  assign prod = a * b;

  always_comb begin
    res       = '0;
    req       = '0;
    take      = 1'b0;
    res.npc   = pc4;
    res.ld_f3 = f3;

    unique case (op)
      OP_LOAD: begin
        case (f3) inside
          F3_LB, F3_LBU: begin
            res.maddr   = agen;
            res.wr      = 1'b1;
            res.is_load = 1'b1;
            req.rd_en   = 1'b1;
          end
          F3_LH, F3_LHU: begin
            res.maddr = agen;
            if (agen[0]) begin
              res.mis = 1'b1;
            end else begin
              res.wr      = 1'b1;
              res.is_load = 1'b1;
              req.rd_en   = 1'b1;
            end
          end
          F3_LW: begin
            res.maddr = agen;
            if (|agen[1:0]) begin
              res.mis = 1'b1;
            end else begin
              res.wr      = 1'b1;
              res.is_load = 1'b1;
              req.rd_en   = 1'b1;
            end
          end
          default: res.uns = 1'b1;
        endcase
      end
      OP_STORE: begin
        case (f3)
          F3_SB: begin
            res.maddr     = agen;
            res.mem_write = 1'b1;
            req.wr_en     = 1'b1;
            req.be        = 4'b0001 << agen[1:0];
            req.wdata     = {4{b[7:0]}};
          end
          F3_SH: begin
            res.maddr = agen;
            if (agen[0]) begin
              res.mis = 1'b1;
            end else begin
              res.mem_write = 1'b1;
              req.wr_en     = 1'b1;
              req.be        = agen[1] ? 4'b1100 : 4'b0011;
              req.wdata     = {2{b[15:0]}};
            end
          end
          F3_SW: begin
            res.maddr = agen;
            if (|agen[1:0]) begin
              res.mis = 1'b1;
            end else begin
              res.mem_write = 1'b1;
              req.wr_en     = 1'b1;
              req.be        = 4'b1111;
              req.wdata     = b;
            end
          end
          default: res.uns = 1'b1;
        endcase
      end
      OP_IMM: begin
        case (f3)
          F3_ADDI: begin
            res.val = agen;
            res.wr  = 1'b1;
          end
          F3_ANDI: begin
            res.val = a & immi;
            res.wr  = 1'b1;
          end
          F3_SLLI: begin
            if (f7 == F7_BASE) begin
              res.val = a << shamt;
              res.wr  = 1'b1;
            end else begin
              res.uns = 1'b1;
            end
          end
          F3_SRI: begin
            if (f7 == F7_BASE) begin
              res.val = a >> shamt;
              res.wr  = 1'b1;
            end else if (f7 == F7_ALT) begin
              res.val = 32'($signed(a) >>> shamt);
              res.wr  = 1'b1;
            end else begin
              res.uns = 1'b1;
            end
          end
          default: res.uns = 1'b1;
        endcase
      end
      OP_REG: begin
        if (f3 != F3_ADD) begin
          res.uns = 1'b1;
        end else begin
          case (f7)
            F7_BASE: begin
              res.val = a + b;
              res.wr  = 1'b1;
            end
            F7_ALT: begin
              res.val = a - b;
              res.wr  = 1'b1;
            end
            F7_MUL: begin
              res.val = prod;
              res.wr  = 1'b1;
            end
            default: res.uns = 1'b1;
          endcase
        end
      end
      OP_LUI: begin
        res.val = {ins[31:12], 12'b0};
        res.wr  = 1'b1;
      end
      OP_JAL: begin
        res.val = pc4;
        res.wr  = 1'b1;
        res.npc = btgt;
      end
      OP_JALR: begin
        if (f3 != F3_JALR) begin
          res.uns = 1'b1;
        end else begin
          res.npc = {agen[31:1], 1'b0};
          res.val = pc4;
          res.wr  = 1'b1;
        end
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  take = (a == b);
          F3_BNE:  take = (a != b);
          F3_BLT:  take = ($signed(a) < $signed(b));
          F3_BGE:  take = ($signed(a) >= $signed(b));
          F3_BLTU: take = (a < b);
          F3_BGEU: take = (a >= b);
          default: res.uns = 1'b1;
        endcase
        if (take) begin
          res.npc = btgt;
        end
      end
      default: res.uns = 1'b1;
    endcase

    // Drop writes to x0 and clear the destination fields when nothing is written
    if (res.wr && (rd != 5'd0)) begin
      res.rd = rd;
    end else begin
      res.wr      = 1'b0;
      res.rd      = 5'd0;
      res.val     = '0;
      res.is_load = 1'b0;
    end
  end

endmodule

>>> rtl/rvse_dmem.sv
// Word-wide data memory with byte enables, registered read and post-reset clearing sweep.
module rvse_dmem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rvse_pkg::mem_req_t           req,
  input  logic [rvse_pkg::DMEM_AW-1:0] idx,
  output logic [31:0]                  rdata,
  output logic                         busy
);
  import rvse_pkg::*;

  logic [31:0]        mem [DMEM_WORDS];
  logic [31:0]        rdata_r;
  logic               clr_busy_r;
  logic [DMEM_AW-1:0] clr_idx_r;

  // Sweep every word to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == DMEM_AW'(DMEM_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Write the clearing sweep or the byte lanes of a store
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (req.wr_en) begin
      for (int i = 0; i < 4; i++) begin
        if (req.be[i]) begin
          mem[idx][8*i +: 8] <= req.wdata[8*i +: 8];
        end
      end
    end
  end

  // Register the read word, hold it until the next load
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= mem[idx];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clr_busy_r;

endmodule

>>> rtl/rv32i_subset_execute.sv
// Top level: three-stage execute pipeline with register file, PC and data memory.
//
// Each input transaction carries one 32-bit instruction; each produces exactly one
// result transaction (next PC, register write, store flag, effective address and
// misaligned/unsupported flags), in order. Both channels use valid/stall.
//
// Pipeline: execute register (decode, ALU, branch, memory access), writeback
// register (load data from the registered memory read), output register.
// One instruction is accepted per cycle while in_stall is low, set by the single data
// memory port used in the execute stage. Results from writeback are forwarded to the
// instruction in execute, so back-to-back dependent instructions, loads included, run
// without bubbles.
//
// Reset clears the register file (per-entry valid bits), the PC and all stage
// valids, then a sweep zeroes the 4096 words of data memory, during which in_stall
// stays high. When out_stall holds a result, the stages behind it keep filling until
// each holds one instruction, then in_stall rises.
module rv32i_subset_execute (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_next_pc,
  output logic        out_reg_write,
  output logic [4:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic        out_mem_write,
  output logic [31:0] out_mem_address,
  output logic        out_misaligned,
  output logic        out_unsupported
);
  import rvse_pkg::*;

  // Register file with per-entry valid bits standing in for the reset clear
  logic [31:0] rf_r [32];
  logic [31:0] rf_vld_r;

  // Execute stage
  logic        e_v_r;
  logic [31:0] e_ins_r;
  logic [31:0] a_r;
  logic [31:0] b_r;
  logic [31:0] a_nxt;
  logic [31:0] b_nxt;
  logic [31:0] pc_r;
  logic [31:0] a_fwd;
  logic [31:0] b_fwd;
  exec_res_t   e_res;
  mem_req_t    e_req;
  mem_req_t    dmem_req;

  // Writeback stage
  logic        w_v_r;
  exec_res_t   w_res_r;
  logic [31:0] dmem_rdata;
  logic        dmem_busy;
  logic [31:0] wb_val;
  logic        wb_we;

  // Output register
  logic        out_v_r;
  logic [31:0] out_next_pc_r;
  logic        out_reg_write_r;
  logic [4:0]  out_reg_index_r;
  logic [31:0] out_reg_value_r;
  logic        out_mem_write_r;
  logic [31:0] out_mem_address_r;
  logic        out_misaligned_r;
  logic        out_unsupported_r;

  // Handshake and stage advance
  logic out_adv;
  logic w_adv;
  logic w_fire;
  logic e_fire;
  logic in_fire;
  logic wb_fire;

  // Pick and extend the loaded bytes from the memory word
  function automatic logic [31:0] load_ext(input logic [31:0] word, input logic [2:0] f3,
                                           input logic [1:0] off);
    logic [31:0] sh;
    sh = word >> {off, 3'b000};
    unique case (f3)
      F3_LB:   return {{24{sh[7]}}, sh[7:0]};
      F3_LH:   return {{16{sh[15]}}, sh[15:0]};
      F3_LBU:  return {24'b0, sh[7:0]};
      F3_LHU:  return {16'b0, sh[15:0]};
      default: return word;
    endcase
  endfunction

  assign out_adv  = ~out_v_r | ~out_stall;
  assign w_adv    = ~w_v_r | out_adv;
  assign w_fire   = w_v_r & out_adv;
  assign e_fire   = e_v_r & w_adv;
  assign in_stall = dmem_busy | (e_v_r & ~w_adv);
  assign in_fire  = in_valid & ~in_stall;

  // Writeback value and register file write
  assign wb_val  = w_res_r.is_load ? load_ext(dmem_rdata, w_res_r.ld_f3, w_res_r.maddr[1:0])
                                   : w_res_r.val;
  assign wb_we   = w_v_r & w_res_r.wr;
  assign wb_fire = wb_we & out_adv;

  // Operand capture: read at acceptance, track writebacks while held
  always_comb begin
    if (in_fire) begin
      if (wb_fire && (w_res_r.rd == in_instruction[19:15])) begin
        a_nxt = wb_val;
      end else begin
        a_nxt = rf_vld_r[in_instruction[19:15]] ? rf_r[in_instruction[19:15]] : '0;
      end
      if (wb_fire && (w_res_r.rd == in_instruction[24:20])) begin
        b_nxt = wb_val;
      end else begin
        b_nxt = rf_vld_r[in_instruction[24:20]] ? rf_r[in_instruction[24:20]] : '0;
      end
    end else begin
      a_nxt = (wb_fire && (w_res_r.rd == e_ins_r[19:15])) ? wb_val : a_r;
      b_nxt = (wb_fire && (w_res_r.rd == e_ins_r[24:20])) ? wb_val : b_r;
    end
  end

  // Forward the pending writeback into execute
  assign a_fwd = (wb_we && (w_res_r.rd == e_ins_r[19:15])) ? wb_val : a_r;
  assign b_fwd = (wb_we && (w_res_r.rd == e_ins_r[24:20])) ? wb_val : b_r;

  rvse_exec u_exec (
    .ins (e_ins_r),
    .pc  (pc_r),
    .a   (a_fwd),
    .b   (b_fwd),
    .res (e_res),
    .req (e_req)
  );

  // Issue the memory access only when the instruction leaves execute
  always_comb begin
    dmem_req       = e_req;
    dmem_req.rd_en = e_req.rd_en & e_fire;
    dmem_req.wr_en = e_req.wr_en & e_fire;
  end

  rvse_dmem u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dmem_req),
    .idx   (e_res.maddr[DMEM_AW+1:2]),
    .rdata (dmem_rdata),
    .busy  (dmem_busy)
  );

  // Control state: stage valids, PC, register valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r    <= 1'b0;
      w_v_r    <= 1'b0;
      out_v_r  <= 1'b0;
      pc_r     <= '0;
      rf_vld_r <= '0;
    end else begin
      if (in_fire) begin
        e_v_r <= 1'b1;
      end else if (e_fire) begin
        e_v_r <= 1'b0;
      end
      if (w_adv) begin
        w_v_r <= e_v_r;
      end
      if (out_adv) begin
        out_v_r <= w_v_r;
      end
      if (e_fire) begin
        pc_r <= e_res.npc;
      end
      if (wb_fire) begin
        rf_vld_r[w_res_r.rd] <= 1'b1;
      end
    end
  end

  // Payload: instruction, operands, register file, stage contents
  always_ff @(posedge clk) begin
    if (in_fire) begin
      e_ins_r <= in_instruction;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    if (wb_fire) begin
      rf_r[w_res_r.rd] <= wb_val;
    end
    if (e_fire) begin
      w_res_r <= e_res;
    end
    if (w_fire) begin
      out_next_pc_r     <= w_res_r.npc;
      out_reg_write_r   <= w_res_r.wr;
      out_reg_index_r   <= w_res_r.rd;
      out_reg_value_r   <= wb_val;
      out_mem_write_r   <= w_res_r.mem_write;
      out_mem_address_r <= w_res_r.maddr;
      out_misaligned_r  <= w_res_r.mis;
      out_unsupported_r <= w_res_r.uns;
    end
  end

  assign out_valid       = out_v_r;
  assign out_next_pc     = out_next_pc_r;
  assign out_reg_write   = out_reg_write_r;
  assign out_reg_index   = out_reg_index_r;
  assign out_reg_value   = out_reg_value_r;
  assign out_mem_write   = out_mem_write_r;
  assign out_mem_address = out_mem_address_r;
  assign out_misaligned  = out_misaligned_r;
  assign out_unsupported = out_unsupported_r;

endmodule

>>> rtl/rvse_checker.sv
// Port-level checker for the execute block, bound to the top level.
module rvse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_next_pc,
  input logic        out_reg_write,
  input logic [4:0]  out_reg_index,
  input logic [31:0] out_reg_value,
  input logic        out_mem_write,
  input logic        out_misaligned,
  input logic        out_unsupported
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_next_pc) && $stable(out_reg_value))
    else $error("stalled result transaction changed");

  // No register write means empty destination fields
  a_no_wr_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reg_write |-> out_reg_index == 5'd0 && out_reg_value == 32'd0)
    else $error("destination fields set without a register write");

  // Suppressed instructions change no state
  a_suppressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_misaligned || out_unsupported) |-> !out_reg_write && !out_mem_write)
    else $error("suppressed instruction reported a write");

  // Flags are exclusive
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_misaligned && out_unsupported) && !(out_reg_write && out_mem_write))
    else $error("conflicting result flags");

  // Memory clearing holds off input right after reset
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input accepted during memory clearing");

endmodule

bind rv32i_subset_execute rvse_checker u_rvse_checker (.*);

>>> tb/rv32i_subset_execute_test.sv
// Testbench for the RV32I subset execute block: directed and random instruction streams against a predictor.
`timescale 1ns / 100ps

module rv32i_subset_execute_test;
  import rvse_pkg::*;

  localparam int N_RANDOM   = 950;
  localparam int PHASE_LEN  = 330;
  localparam int HOLD_LEN   = 60;
  // Encodings outside the implemented set
  localparam logic [2:0] F3_LD_RSVD = 3'b011;
  localparam logic [2:0] F3_BR_RSVD = 3'b010;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [31:0] mem_address;
    logic        misaligned;
    logic        unsupported;
  } retire_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_instruction = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_next_pc;
  logic        out_reg_write;
  logic [4:0]  out_reg_index;
  logic [31:0] out_reg_value;
  logic        out_mem_write;
  logic [31:0] out_mem_address;
  logic        out_misaligned;
  logic        out_unsupported;

  // Architectural state mirrored by the predictor
  logic [31:0] gpr [32];
  logic [31:0] pc_model;
  logic [7:0]  dmem [MEM_BYTES];

  logic [31:0] instr_q [$];
  retire_t     retire_q [$];
  int          n_accepted = 0;
  int          n_results = 0;
  int          n_errors = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  rv32i_subset_execute i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_instruction  (in_instruction),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_next_pc     (out_next_pc),
    .out_reg_write   (out_reg_write),
    .out_reg_index   (out_reg_index),
    .out_reg_value   (out_reg_value),
    .out_mem_write   (out_mem_write),
    .out_mem_address (out_mem_address),
    .out_misaligned  (out_misaligned),
    .out_unsupported (out_unsupported)
  );

  always #5 clk = ~clk;

  // Instruction encoders
  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  // Little-endian memory access with wrap at the end of memory
  function automatic logic [31:0] mem_load(logic [31:0] addr, int nbytes);
    logic [31:0] v;
    logic [31:0] ea;
    int          i;
    v = '0;
    for (i = 0; i < nbytes; i++) begin
      ea = addr + i;
      v[8*i +: 8] = dmem[ea % MEM_BYTES];
    end
    return v;
  endfunction

  function automatic void mem_store(logic [31:0] addr, int nbytes, logic [31:0] v);
    logic [31:0] ea;
    int          i;
    for (i = 0; i < nbytes; i++) begin
      ea = addr + i;
      dmem[ea % MEM_BYTES] = v[8*i +: 8];
    end
  endfunction

  // Execute one instruction against the mirrored state and return its retirement record
  function automatic retire_t execute_instr(logic [31:0] ins);
    logic [6:0]  opcode;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [2:0]  f3;
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j;
    logic [31:0] npc, val, maddr;
    logic        wr, mw, mis, uns, take;
    opcode = ins[6:0];
    rd     = ins[11:7];
    f3     = ins[14:12];
    rs1    = ins[19:15];
    rs2    = ins[24:20];
    f7     = ins[31:25];
    a      = gpr[rs1];
    b      = gpr[rs2];
    imm_i  = {{20{ins[31]}}, ins[31:20]};
    imm_s  = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    imm_b  = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    imm_j  = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    npc    = pc_model + 32'd4;
    val    = '0;
    maddr  = '0;
    {wr, mw, mis, uns, take} = '0;
    case (opcode)
      OP_LOAD: begin
        maddr = a + imm_i;
        case (f3)
          F3_LB: begin
            val = mem_load(maddr, 1);
            val = {{24{val[7]}}, val[7:0]};
            wr  = 1'b1;
          end
          F3_LH: begin
            if (maddr[0]) begin
              mis = 1'b1;
            end else begin
              val = mem_load(maddr, 2);
              val = {{16{val[15]}}, val[15:0]};
              wr  = 1'b1;
            end
          end
          F3_LW: begin
            if (maddr[1:0] != 2'b00) begin
              mis = 1'b1;
            end else begin
              val = mem_load(maddr, 4);
              wr  = 1'b1;
            end
          end
          F3_LBU: begin
            val = mem_load(maddr, 1);
            wr  = 1'b1;
          end
          F3_LHU: begin
            if (maddr[0]) begin
              mis = 1'b1;
            end else begin
              val = mem_load(maddr, 2);
              wr  = 1'b1;
            end
          end
          default: begin
            uns   = 1'b1;
            maddr = '0;
          end
        endcase
      end
      OP_STORE: begin
        maddr = a + imm_s;
        case (f3)
          F3_SB: begin
            mem_store(maddr, 1, b);
            mw = 1'b1;
          end
          F3_SH: begin
            if (maddr[0]) begin
              mis = 1'b1;
            end else begin
              mem_store(maddr, 2, b);
              mw = 1'b1;
            end
          end
          F3_SW: begin
            if (maddr[1:0] != 2'b00) begin
              mis = 1'b1;
            end else begin
              mem_store(maddr, 4, b);
              mw = 1'b1;
            end
          end
          default: begin
            uns   = 1'b1;
            maddr = '0;
          end
        endcase
      end
      OP_IMM: begin
        case (f3)
          F3_ADDI: begin
            val = a + imm_i;
            wr  = 1'b1;
          end
          F3_ANDI: begin
            val = a & imm_i;
            wr  = 1'b1;
          end
          F3_SLLI: begin
            if (f7 == F7_BASE) begin
              val = a << imm_i[4:0];
              wr  = 1'b1;
            end else begin
              uns = 1'b1;
            end
          end
          F3_SRI: begin
            if (f7 == F7_BASE) begin
              val = a >> imm_i[4:0];
              wr  = 1'b1;
            end else if (f7 == F7_ALT) begin
              val = $signed(a) >>> imm_i[4:0];
              wr  = 1'b1;
            end else begin
              uns = 1'b1;
            end
          end
          default: uns = 1'b1;
        endcase
      end
      OP_REG: begin
        if (f3 != F3_ADD) begin
          uns = 1'b1;
        end else begin
          case (f7)
            F7_BASE: val = a + b;
            F7_ALT:  val = a - b;
            F7_MUL:  val = a * b;
            default: uns = 1'b1;
          endcase
          wr = !uns;
        end
      end
      OP_LUI: begin
        val = {ins[31:12], 12'b0};
        wr  = 1'b1;
      end
      OP_JAL: begin
        val = pc_model + 32'd4;
        npc = pc_model + imm_j;
        wr  = 1'b1;
      end
      OP_JALR: begin
        if (f3 != F3_JALR) begin
          uns = 1'b1;
        end else begin
          // target from rs1 as read before the link write
          npc = (a + imm_i) & ~32'd1;
          val = pc_model + 32'd4;
          wr  = 1'b1;
        end
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  take = (a == b);
          F3_BNE:  take = (a != b);
          F3_BLT:  take = ($signed(a) < $signed(b));
          F3_BGE:  take = ($signed(a) >= $signed(b));
          F3_BLTU: take = (a < b);
          F3_BGEU: take = (a >= b);
          default: uns = 1'b1;
        endcase
        if (take) npc = pc_model + imm_b;
      end
      default: uns = 1'b1;
    endcase
    // x0 never changes
    if (wr && rd != 5'd0) begin
      gpr[rd] = val;
    end else begin
      wr  = 1'b0;
      val = '0;
      rd  = '0;
    end
    pc_model = npc;
    return '{npc, wr, rd, val, mw, maddr, mis, uns};
  endfunction

  // Memory offset: mostly near address zero so stores and loads meet, aligned most of the time
  function automatic logic [11:0] mem_offset(logic [2:0] f3);
    logic [11:0] imm;
    imm = 12'($urandom_range(0, 4095));
    if ($urandom_range(99) < 80) begin
      if (f3[1:0] == 2'b10) imm[1:0] = 2'b00;
      else if (f3[1:0] == 2'b01) imm[0] = 1'b0;
    end
    return imm;
  endfunction

  // Random instruction: mostly well-formed with random operands, some noise
  function automatic logic [31:0] rand_instr();
    logic [2:0]  ld_f3 [5] = '{F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU};
    logic [2:0]  st_f3 [3] = '{F3_SB, F3_SH, F3_SW};
    logic [2:0]  im_f3 [4] = '{F3_ADDI, F3_SLLI, F3_SRI, F3_ANDI};
    logic [6:0]  f7_set [3] = '{F7_BASE, F7_ALT, F7_MUL};
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    int          sel;
    sel = $urandom_range(99);
    rd  = 5'($urandom);
    rs1 = ($urandom_range(1) == 0) ? 5'd0 : 5'($urandom);
    rs2 = 5'($urandom);
    if (sel < 10) begin
      return $urandom;
    end else if (sel < 25) begin
      f3 = ($urandom_range(9) == 0) ? 3'($urandom) : ld_f3[$urandom_range(4)];
      return enc_i(mem_offset(f3), rs1, f3, rd, OP_LOAD);
    end else if (sel < 40) begin
      f3 = ($urandom_range(9) == 0) ? 3'($urandom) : st_f3[$urandom_range(2)];
      return enc_s(mem_offset(f3), rs2, rs1, f3);
    end else if (sel < 55) begin
      f3 = ($urandom_range(6) == 0) ? 3'($urandom) : im_f3[$urandom_range(3)];
      f7 = ($urandom_range(9) == 0) ? 7'($urandom) : f7_set[$urandom_range(1)];
      if (f3 == F3_SLLI || f3 == F3_SRI)
        return enc_i({f7, 5'($urandom)}, 5'($urandom), f3, rd, OP_IMM);
      return enc_i(12'($urandom), 5'($urandom), f3, rd, OP_IMM);
    end else if (sel < 68) begin
      f3 = ($urandom_range(9) == 0) ? 3'($urandom) : F3_ADD;
      f7 = ($urandom_range(9) == 0) ? 7'($urandom) : f7_set[$urandom_range(2)];
      return enc_r(f7, rs2, 5'($urandom), f3, rd);
    end else if (sel < 74) begin
      return {20'($urandom), rd, OP_LUI};
    end else if (sel < 80) begin
      return enc_j(21'($urandom), rd);
    end else if (sel < 86) begin
      f3 = ($urandom_range(9) == 0) ? 3'($urandom) : F3_JALR;
      return enc_i(12'($urandom), 5'($urandom), f3, rd, OP_JALR);
    end else if (sel < 96) begin
      return enc_b(13'($urandom), rs2, 5'($urandom), 3'($urandom));
    end
    return {25'($urandom), 7'($urandom)};
  endfunction

  function automatic int idle_pct(int done, bit receiver);
    if (done < PHASE_LEN) return receiver ? 72 : 15;
    if (done < 2 * PHASE_LEN) return receiver ? 15 : 72;
    return 0;
  endfunction

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, int seq, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("transaction %0d %s: got %h, expected %h",
                                seq, name, got, want));
  endtask

  // Driver: predict on acceptance, then offer the next instruction or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        retire_q.push_back(execute_instr(in_instruction));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (instr_q.size() != 0 && $urandom_range(99) >= idle_pct(n_accepted, 1'b0)) begin
          in_valid       <= 1'b1;
          in_instruction <= instr_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once, at full input rate, to back the pipeline up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_results >= 2 * PHASE_LEN + 50) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin : monitor
    retire_t got;
    retire_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_next_pc, out_reg_write, out_reg_index, out_reg_value,
                out_mem_write, out_mem_address, out_misaligned, out_unsupported};
        if (retire_q.size() == 0) begin
          report_mismatch($sformatf("transaction %0d: result with no instruction pending",
                                    n_results));
        end else begin
          want = retire_q.pop_front();
          check_field("next_pc", n_results, got.next_pc, want.next_pc);
          check_field("reg_write", n_results, 32'(got.reg_write), 32'(want.reg_write));
          check_field("reg_index", n_results, 32'(got.reg_index), 32'(want.reg_index));
          check_field("reg_value", n_results, got.reg_value, want.reg_value);
          check_field("mem_write", n_results, 32'(got.mem_write), 32'(want.mem_write));
          check_field("mem_address", n_results, got.mem_address, want.mem_address);
          check_field("misaligned", n_results, 32'(got.misaligned), 32'(want.misaligned));
          check_field("unsupported", n_results, 32'(got.unsupported), 32'(want.unsupported));
        end
        n_results <= n_results + 1;
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < idle_pct(n_results, 1'b1));
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int i;
    foreach (gpr[k]) gpr[k] = '0;
    foreach (dmem[k]) dmem[k] = '0;
    pc_model = '0;

    // Operand extremes and write to x0
    instr_q.push_back(enc_i(12'hFFF, 5'd0, F3_ADDI, 5'd1, OP_IMM));
    instr_q.push_back({20'h80000, 5'd2, OP_LUI});
    instr_q.push_back(enc_i(12'h005, 5'd1, F3_ADDI, 5'd0, OP_IMM));
    instr_q.push_back(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd3));
    instr_q.push_back(enc_r(F7_ALT, 5'd1, 5'd0, F3_ADD, 5'd4));
    instr_q.push_back(enc_r(F7_MUL, 5'd1, 5'd2, F3_ADD, 5'd5));
    instr_q.push_back(enc_i({F7_BASE, 5'd31}, 5'd1, F3_SLLI, 5'd6, OP_IMM));
    instr_q.push_back(enc_i({F7_BASE, 5'd31}, 5'd2, F3_SRI, 5'd7, OP_IMM));
    instr_q.push_back(enc_i({F7_ALT, 5'd31}, 5'd2, F3_SRI, 5'd8, OP_IMM));
    instr_q.push_back(enc_i(12'h800, 5'd1, F3_ANDI, 5'd9, OP_IMM));
    // Stores and loads, including a negative address that wraps to the top of memory
    instr_q.push_back(enc_s(12'hFFC, 5'd5, 5'd0, F3_SW));
    instr_q.push_back(enc_s(12'h7FF, 5'd1, 5'd0, F3_SB));
    instr_q.push_back(enc_i(12'hFFC, 5'd0, F3_LW, 5'd10, OP_LOAD));
    instr_q.push_back(enc_i(12'hFFE, 5'd0, F3_LH, 5'd11, OP_LOAD));
    instr_q.push_back(enc_i(12'hFFE, 5'd0, F3_LHU, 5'd12, OP_LOAD));
    instr_q.push_back(enc_i(12'h7FF, 5'd0, F3_LB, 5'd13, OP_LOAD));
    instr_q.push_back(enc_i(12'h7FF, 5'd0, F3_LBU, 5'd14, OP_LOAD));
    // Misaligned accesses
    instr_q.push_back(enc_i(12'h001, 5'd0, F3_LW, 5'd15, OP_LOAD));
    instr_q.push_back(enc_s(12'h003, 5'd1, 5'd0, F3_SH));
    // Unsupported encodings
    instr_q.push_back(32'hFFFF_FFFF);
    instr_q.push_back(enc_i(12'h004, 5'd0, F3_LD_RSVD, 5'd16, OP_LOAD));
    instr_q.push_back(enc_i({F7_MUL, 5'd3}, 5'd1, F3_SRI, 5'd17, OP_IMM));
    instr_q.push_back(enc_b(13'h0008, 5'd0, 5'd0, F3_BR_RSVD));
    // Jumps: JAL at its most negative reach, then JALR reading its own link register
    instr_q.push_back(enc_j(21'h100000, 5'd18));
    instr_q.push_back(enc_i(12'h007, 5'd18, F3_JALR, 5'd18, OP_JALR));
    // Every branch condition, signed and unsigned order disagreeing
    instr_q.push_back(enc_b(13'h0FFE, 5'd0, 5'd0, F3_BEQ));
    instr_q.push_back(enc_b(13'h0010, 5'd0, 5'd0, F3_BNE));
    instr_q.push_back(enc_b(13'h1000, 5'd0, 5'd2, F3_BLT));
    instr_q.push_back(enc_b(13'h0020, 5'd2, 5'd0, F3_BGE));
    instr_q.push_back(enc_b(13'h0040, 5'd0, 5'd2, F3_BLTU));
    instr_q.push_back(enc_b(13'h1FFE, 5'd0, 5'd2, F3_BGEU));
    for (i = 0; i < N_RANDOM; i++) instr_q.push_back(rand_instr());

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: everything sent and every result back
    do @(posedge clk);
    while (instr_q.size() != 0 || in_valid || retire_q.size() != 0);
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("rv32i_subset_execute verification clean");
    end else begin
      $display("rv32i_subset_execute verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("rv32i_subset_execute verification failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/rvse_pkg.sv
rtl/rvse_exec.sv
rtl/rvse_dmem.sv
rtl/rv32i_subset_execute.sv
rtl/rvse_checker.sv
tb/rv32i_subset_execute_test.sv
